// ===== src/ldfog_pkg.sv =====
// ----------------------------------------------------------------------------
// ldfog_pkg
// Shared constants and register indexes of the linear distance fog blend.
// ----------------------------------------------------------------------------
package ldfog_pkg;

	// fixed-point fraction bits of coordinates and distances
	localparam int FRAC_BITS  = 8;
	localparam int COORD_W    = 24;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int ROOT_W     = DIFF_W;
	localparam int REM_W      = ROOT_W + 3;
	localparam int DIST_W     = 25;
	localparam int STR_W      = 9;
	localparam int NUM_W      = STR_W + DIST_W;
	localparam int W_W        = 9;
	localparam int CH_W       = 8;
	localparam int CFG_W      = 24;
	localparam int IDX_W      = 3;

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_CAMERA_X = 3'd0,
		REG_CAMERA_Y = 3'd1,
		REG_CAMERA_Z = 3'd2,
		REG_NEAR     = 3'd3,
		REG_FAR      = 3'd4,
		REG_STRENGTH = 3'd5,
		REG_FOG_RGB  = 3'd6
	} reg_idx_t;

	localparam logic [CFG_W-1:0] FAR_RESET = CFG_W'(1 << FRAC_BITS);
	localparam logic [STR_W-1:0] STR_ONE   = STR_W'(256);

endpackage

// ===== src/linear_distance_fog_blend.sv =====
// ----------------------------------------------------------------------------
// linear_distance_fog_blend
// Per-point linear distance fog: distance to camera, weight, color blend.
// ----------------------------------------------------------------------------
// A fully pipelined block that takes one point per clock while in_stall is
// low and returns one fogged color per point. The depth comes from
// the square root (one root bit per stage, 25 stages) and the weight divider
// (one quotient bit per stage, 9 stages). When the output transaction is
// stalled the whole pipeline holds and in_stall is raised. Registers may be
// written only while no point is in flight.
module linear_distance_fog_blend (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [ldfog_pkg::IDX_W-1:0]      wr_index,
	input  logic [ldfog_pkg::CFG_W-1:0]      wr_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [23:0]               point_x,
	input  logic signed [23:0]               point_y,
	input  logic signed [23:0]               point_z,
	input  logic [7:0]                       in_red,
	input  logic [7:0]                       in_green,
	input  logic [7:0]                       in_blue,
	input  logic [7:0]                       in_alpha,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_red,
	output logic [7:0]                       out_green,
	output logic [7:0]                       out_blue,
	output logic [7:0]                       out_alpha
);
	import ldfog_pkg::*;

	localparam int SQ_STAGES  = ROOT_W;
	localparam int DIV_STAGES = W_W;

	logic [CFG_W-1:0] cam_x_q, cam_y_q, cam_z_q, near_q, far_q, rgb_q;
	logic [STR_W-1:0] str_q;
	logic             adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			near_q  <= '0;
			far_q   <= FAR_RESET;
			str_q   <= '0;
			rgb_q   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CAMERA_X: cam_x_q <= wr_data;
				REG_CAMERA_Y: cam_y_q <= wr_data;
				REG_CAMERA_Z: cam_z_q <= wr_data;
				REG_NEAR:     near_q  <= wr_data;
				REG_FAR:      far_q   <= wr_data;
				REG_STRENGTH: str_q   <= wr_data[STR_W-1:0];
				REG_FOG_RGB:  rgb_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// pipeline moves unless a result is waiting on a stalled output
	assign adv      = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;

	// sanitized registers
	logic [DIST_W-1:0] far_eff;
	logic [STR_W-1:0]  str_sat;
	assign far_eff = (far_q <= near_q) ? (DIST_W'(near_q) + DIST_W'(1 << FRAC_BITS))
	                                   : DIST_W'(far_q);
	assign str_sat = (str_q > STR_ONE) ? STR_ONE : str_q;

	// stage 1: absolute coordinate differences
	logic              v_s1;
	logic [DIFF_W-1:0] ax_s1, ay_s1, az_s1;
	logic [31:0]       col_s1;

	function automatic logic [DIFF_W-1:0] abs_diff(logic [COORD_W-1:0] a,
	                                               logic [COORD_W-1:0] b);
		logic [DIFF_W-1:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1  <= abs_diff(point_x, cam_x_q);
			ay_s1  <= abs_diff(point_y, cam_y_q);
			az_s1  <= abs_diff(point_z, cam_z_q);
			col_s1 <= {in_red, in_green, in_blue, in_alpha};
		end
	end

	// stage 2: squares
	logic            v_s2;
	logic [SQ_W-1:0] sx_s2, sy_s2, sz_s2;
	logic [31:0]     col_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s2  <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			sy_s2  <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
			sz_s2  <= SQ_W'(az_s1) * SQ_W'(az_s1);
			col_s2 <= col_s1;
		end
	end

	// stage 3: sum of squares
	logic            v_s3;
	logic [SQ_W-1:0] sum_s3;
	logic [31:0]     col_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= sx_s2 + sy_s2 + sz_s2;
			col_s3 <= col_s2;
		end
	end

	// square root: one root bit per stage
	logic              sqv_s   [SQ_STAGES+1];
	logic [SQ_W-1:0]   sqn_s   [SQ_STAGES+1];
	logic [REM_W-1:0]  sqrem_s [SQ_STAGES+1];
	logic [ROOT_W-1:0] sqrt_s  [SQ_STAGES+1];
	logic [31:0]       sqcol_s [SQ_STAGES+1];

	assign sqv_s[0]   = v_s3;
	assign sqn_s[0]   = sum_s3;
	assign sqrem_s[0] = '0;
	assign sqrt_s[0]  = '0;
	assign sqcol_s[0] = col_s3;

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		assign rem_sh = {sqrem_s[k][REM_W-3:0], sqn_s[k][SQ_W-1 -: 2]};
		assign trial  = REM_W'({sqrt_s[k], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sqv_s[k+1] <= 1'b0;
			else if (adv) sqv_s[k+1] <= sqv_s[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sqn_s[k+1]   <= {sqn_s[k][SQ_W-3:0], 2'b00};
				sqcol_s[k+1] <= sqcol_s[k];
				if (rem_sh >= trial) begin
					sqrem_s[k+1] <= rem_sh - trial;
					sqrt_s[k+1]  <= {sqrt_s[k][ROOT_W-2:0], 1'b1};
				end else begin
					sqrem_s[k+1] <= rem_sh;
					sqrt_s[k+1]  <= {sqrt_s[k][ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	// stage a: clamp and offset distance
	logic              v_sa;
	logic              lt_sa;
	logic [DIST_W-1:0] dn_sa, den_sa;
	logic [31:0]       col_sa;
	logic [DIST_W-1:0] dist_raw, dclamp;
	assign dist_raw = DIST_W'(sqrt_s[SQ_STAGES]);
	assign dclamp   = (dist_raw > far_eff) ? far_eff : dist_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sa <= 1'b0;
		else if (adv) v_sa <= sqv_s[SQ_STAGES];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			lt_sa  <= dist_raw < DIST_W'(near_q);
			dn_sa  <= dclamp - DIST_W'(near_q);
			den_sa <= far_eff - DIST_W'(near_q);
			col_sa <= sqcol_s[SQ_STAGES];
		end
	end

	// stage b: weight numerator, zero for points nearer than near
	logic              v_sb;
	logic [NUM_W-1:0]  num_sb;
	logic [DIST_W-1:0] den_sb;
	logic [31:0]       col_sb;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sb <= 1'b0;
		else if (adv) v_sb <= v_sa;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			num_sb <= lt_sa ? '0 : NUM_W'(str_sat) * NUM_W'(dn_sa);
			den_sb <= den_sa;
			col_sb <= col_sa;
		end
	end

	// weight divider: one quotient bit per stage, msb first
	logic              dv_s   [DIV_STAGES+1];
	logic [NUM_W-1:0]  drem_s [DIV_STAGES+1];
	logic [DIST_W-1:0] dden_s [DIV_STAGES+1];
	logic [W_W-1:0]    dq_s   [DIV_STAGES+1];
	logic [31:0]       dcol_s [DIV_STAGES+1];

	assign dv_s[0]   = v_sb;
	assign drem_s[0] = num_sb;
	assign dden_s[0] = den_sb;
	assign dq_s[0]   = '0;
	assign dcol_s[0] = col_sb;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		localparam int SH = DIV_STAGES - 1 - k;
		logic [NUM_W-1:0] dsh;
		assign dsh = NUM_W'(dden_s[k]) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_s[k+1] <= 1'b0;
			else if (adv) dv_s[k+1] <= dv_s[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dden_s[k+1] <= dden_s[k];
				dcol_s[k+1] <= dcol_s[k];
				if (drem_s[k] >= dsh) begin
					drem_s[k+1] <= drem_s[k] - dsh;
					dq_s[k+1]   <= {dq_s[k][W_W-2:0], 1'b1};
				end else begin
					drem_s[k+1] <= drem_s[k];
					dq_s[k+1]   <= {dq_s[k][W_W-2:0], 1'b0};
				end
			end
		end
	end

	// stage p: blend products
	logic         v_sp;
	logic [16:0]  br_sp, bg_sp, bb_sp, fr_sp, fg_sp, fb_sp;
	logic [7:0]   a_sp;
	logic [W_W-1:0] w, wi;
	logic [31:0]  colp;
	assign w    = dq_s[DIV_STAGES];
	assign wi   = STR_ONE - w;
	assign colp = dcol_s[DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sp <= 1'b0;
		else if (adv) v_sp <= dv_s[DIV_STAGES];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			br_sp <= 17'(colp[31:24]) * 17'(wi);
			bg_sp <= 17'(colp[23:16]) * 17'(wi);
			bb_sp <= 17'(colp[15:8])  * 17'(wi);
			fr_sp <= 17'(rgb_q[23:16]) * 17'(w);
			fg_sp <= 17'(rgb_q[15:8])  * 17'(w);
			fb_sp <= 17'(rgb_q[7:0])   * 17'(w);
			a_sp  <= colp[7:0];
		end
	end

	// output register: round half up
	logic [17:0] sr, sg, sb;
	assign sr = 18'(br_sp) + 18'(fr_sp) + 18'd128;
	assign sg = 18'(bg_sp) + 18'(fg_sp) + 18'd128;
	assign sb = 18'(bb_sp) + 18'(fb_sp) + 18'd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_sp;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_red   <= sr[15:8];
			out_green <= sg[15:8];
			out_blue  <= sb[15:8];
			out_alpha <= a_sp;
		end
	end

endmodule

// ===== src/ldfog_checker.sv =====
// ----------------------------------------------------------------------------
// ldfog_checker
// Port-level checks of the fog blend handshakes.
// ----------------------------------------------------------------------------
module ldfog_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_red,
	input logic [7:0] out_alpha
);
	import ldfog_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_red) && $stable(out_alpha))
		else $error("result changed while stalled");

	// back-pressure reaches the input when a result waits
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input not stalled behind a waiting result");

	// no stall on the input without a waiting result
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without cause");

endmodule

bind linear_distance_fog_blend ldfog_checker u_ldfog_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_red   (out_red),
	.out_alpha (out_alpha)
);

// ===== tb/tb_linear_distance_fog_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_distance_fog_blend
// Self-checking bench for the per-point linear distance fog blend.
// ----------------------------------------------------------------------------
// Points are queued by a stimulus process and sent by a clocked driver with
// random gaps. A clocked monitor compares every fogged color with a local
// prediction of distance, weight and blend under the current register set.
// Several register settings are applied while the pipeline is empty.
module tb_linear_distance_fog_blend;
	import ldfog_pkg::*;

	typedef struct {
		logic signed [23:0] px, py, pz;
		logic [7:0] r, g, b, a;
	} point_t;

	typedef struct {
		logic [7:0] r, g, b, a;
	} color_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0] wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [23:0] point_x = '0, point_y = '0, point_z = '0;
	logic [7:0] in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_red, out_green, out_blue, out_alpha;

	linear_distance_fog_blend uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// local copy of the register set
	logic [23:0] cam_x = 0, cam_y = 0, cam_z = 0, near_d = 0, far_d = 256, fog_col = 0;
	logic [8:0] strength = 0;

	point_t pending_points[$];
	color_t expected_colors[$];
	int errors = 0;
	int checked = 0;
	int sent = 0;
	longint cycles = 0;

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic [7:0] mix(longint unsigned base, longint unsigned fog,
			longint unsigned w);
		return 8'((base * (256 - w) + fog * w + 128) >> 8);
	endfunction

	// distance, weight and blend for one point
	function automatic color_t fog_point(point_t p);
		color_t c;
		longint dx, dy, dz;
		longint unsigned dist_v, nd, fd, st, w;
		dx = longint'($signed(cam_x)) - longint'(p.px);
		dy = longint'($signed(cam_y)) - longint'(p.py);
		dz = longint'($signed(cam_z)) - longint'(p.pz);
		dist_v = int_sqrt(dx * dx + dy * dy + dz * dz);
		nd = near_d;
		fd = far_d;
		st = (strength > 256) ? 256 : strength;
		if (fd <= nd) fd = nd + (64'd1 << FRAC_BITS);
		c.a = p.a;
		if (dist_v < nd) begin
			c.r = p.r; c.g = p.g; c.b = p.b;
			return c;
		end
		if (dist_v > fd) dist_v = fd;
		w = st * (dist_v - nd) / (fd - nd);
		if (w > 256) w = 256;
		c.r = mix(p.r, fog_col[23:16], w);
		c.g = mix(p.g, fog_col[15:8], w);
		c.b = mix(p.b, fog_col[7:0], w);
		return c;
	endfunction

	// driver: sends queued points with random gaps
	int gap = 0;
	always @(posedge clk) begin
		point_t p;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_colors.push_back(fog_point(pending_points.pop_front()));
				sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap > 0) begin
					gap--;
					in_valid <= 1'b0;
				end else if (pending_points.size() > 0 &&
						!(in_valid && !in_stall && pending_points.size() == 0)) begin
					p = pending_points[0];
					in_valid <= 1'b1;
					point_x <= p.px; point_y <= p.py; point_z <= p.pz;
					in_red <= p.r; in_green <= p.g; in_blue <= p.b; in_alpha <= p.a;
					gap = ($urandom_range(0, 9) < 6) ? 0 :
						(($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
							: $urandom_range(1, 3));
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks results and randomly stalls the output
	int stall_left = 0;
	always @(posedge clk) begin
		color_t e;
		cycles++;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_colors.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected transaction at cycle %0d", cycles);
				end else begin
					e = expected_colors.pop_front();
					checked++;
					if ({out_red, out_green, out_blue, out_alpha} != {e.r, e.g, e.b, e.a}) begin
						errors++;
						if (errors <= 10)
							$display("mismatch rgba exp %h %h %h %h got %h %h %h %h",
								e.r, e.g, e.b, e.a, out_red, out_green, out_blue, out_alpha);
					end
				end
			end
			// output back-pressure: mostly short stalls, a few long ones
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < 20) begin
				stall_left = ($urandom_range(0, 29) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
		if (cycles > 400000) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_points.size() > 0 || in_valid || expected_colors.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [23:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_CAMERA_X: cam_x = val;
			REG_CAMERA_Y: cam_y = val;
			REG_CAMERA_Z: cam_z = val;
			REG_NEAR: near_d = val;
			REG_FAR: far_d = val;
			REG_STRENGTH: strength = val[8:0];
			REG_FOG_RGB: fog_col = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic point_t rand_point(int span);
		point_t p;
		if (span == 0) begin
			p.px = 24'($urandom); p.py = 24'($urandom); p.pz = 24'($urandom);
		end else begin
			p.px = 24'($signed(cam_x) + $signed(24'($urandom_range(0, 2 * span))) - span);
			p.py = 24'($signed(cam_y) + $signed(24'($urandom_range(0, 2 * span))) - span);
			p.pz = 24'($signed(cam_z) + $signed(24'($urandom_range(0, 2 * span))) - span);
		end
		p.r = 8'($urandom); p.g = 8'($urandom); p.b = 8'($urandom); p.a = 8'($urandom);
		return p;
	endfunction

	function automatic point_t mk(int x, int y, int z, logic [7:0] c);
		point_t p;
		p.px = 24'(x); p.py = 24'(y); p.pz = 24'(z);
		p.r = c; p.g = ~c; p.b = c ^ 8'h5a; p.a = ~c ^ 8'h33;
		return p;
	endfunction

	initial begin
		int n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset registers, zero strength passes colors
		pending_points.push_back(mk(0, 0, 0, 8'h00));
		pending_points.push_back(mk(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 8'hff));
		pending_points.push_back(mk(-8388608, -8388608, -8388608, 8'h80));
		wait_drained();

		// directed: full strength, far not beyond near, near cases
		write_reg(REG_STRENGTH, 24'h1ff);
		write_reg(REG_FOG_RGB, 24'hffffff);
		write_reg(REG_NEAR, 24'd1000);
		write_reg(REG_FAR, 24'd500);
		pending_points.push_back(mk(999, 0, 0, 8'h12));
		pending_points.push_back(mk(1000, 0, 0, 8'h34));
		pending_points.push_back(mk(1128, 0, 0, 8'h56));
		pending_points.push_back(mk(1256, 0, 0, 8'h78));
		pending_points.push_back(mk(5000, 0, 0, 8'hff));
		wait_drained();

		// directed: extreme camera, max near and far, strength 256
		write_reg(REG_CAMERA_X, 24'h800000);
		write_reg(REG_CAMERA_Y, 24'h7fffff);
		write_reg(REG_CAMERA_Z, 24'h800000);
		write_reg(REG_NEAR, 24'hffffff);
		write_reg(REG_FAR, 24'hffffff);
		write_reg(REG_STRENGTH, 24'd256);
		write_reg(REG_FOG_RGB, 24'h0);
		pending_points.push_back(mk(24'sh7fffff, -8388608, 24'sh7fffff, 8'hc3));
		pending_points.push_back(mk(0, 0, 0, 8'h3c));
		wait_drained();

		// random phases under a range of register settings
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(REG_CAMERA_X, 24'($urandom));
			write_reg(REG_CAMERA_Y, (ph % 3 == 0) ? 24'h7fffff : 24'($urandom));
			write_reg(REG_CAMERA_Z, 24'($urandom));
			n = $urandom_range(2, 12) << FRAC_BITS;
			write_reg(REG_NEAR, (ph == 9) ? 24'h0 : 24'($urandom_range(0, n)));
			write_reg(REG_FAR, (ph == 4) ? 24'h0 : 24'(near_d + $urandom_range(0, 4 * n)));
			write_reg(REG_STRENGTH, (ph == 2) ? 24'd0 : 24'($urandom_range(0, 300)));
			write_reg(REG_FOG_RGB, 24'($urandom));
			for (int i = 0; i < 55; i++)
				pending_points.push_back(rand_point(
					($urandom_range(0, 9) == 0) ? 0 : 6 * n));
			if (ph == 5) wait_drained();
			for (int i = 0; i < 55; i++) @(posedge clk);
			wait_drained();
		end

		$display("checked %0d fogged points from %0d sent across 13 register settings",
			checked, sent);
		if (errors == 0 && expected_colors.size() == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAIL");
		end
		$finish;
	end

endmodule
